### rtl/assert_macros.svh
// Assertion macros used by the RTL of the curve sampler.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/bcs_pkg.sv
// Shared constants, types and the binomial coefficient table of the curve sampler.
// Depends on nothing.
package bcs_pkg;

    // Port widths fixed by the interface
    localparam int CMD_W       = 1;
    localparam int PIDX_W      = 3;
    localparam int IN_COORD_W  = 16;
    localparam int OUT_W       = 32;
    localparam int SIDX_W      = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int PCOUNT_W    = 4;
    localparam int USTEP_W     = 16;

    // Default parameter values
    localparam int MAX_POINTS_DEF  = 8;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_U_STEP      = 1'b1;

    // Register reset values
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 4'd4;
    localparam logic [USTEP_W-1:0]  USTEP_RESET  = 16'd4096;

    // Q0.16 values carry one extra bit so that 1.0 fits
    localparam int Q_W = 17;
    localparam logic [Q_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [Q_W-1:0] HALF_Q16 = 17'h08000;

    // Multiplier operand A: Q0.16 values, binomials and degree factors
    localparam int MUL_A_W = 18;

    // Binomial coefficients C(m,i) for m up to 15
    localparam int BINOM_N     = 16;
    localparam int BINOM_IDX_W = 4;
    localparam int BINOM_W     = 13;

    typedef logic [BINOM_N-1:0][BINOM_N-1:0][BINOM_W-1:0] binom_tab_t;

    function automatic binom_tab_t build_binom();
        binom_tab_t t;
        t = '0;
        for (int m = 0; m < BINOM_N; m++)
        begin
            t[m][0] = BINOM_W'(1);
            for (int i = 1; i <= m; i++)
            begin
                t[m][i] = t[m-1][i-1] + t[m-1][i];
            end
        end
        return t;
    endfunction

    localparam binom_tab_t BINOM = build_binom();

endpackage

### rtl/bezier_curve_sampler.sv
// Bezier curve sampler: control point store, sequencer and one shared multiplier.
// Depends on bcs_pkg and assert_macros.svh.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 sets
//   point_count (degree is point_count - 1, clamped to 2..MAX_POINTS points),
//   index 1 sets u_step (Q0.16). cfg_ready is always high; write only while idle.
//   Input: in_valid/in_ready. cmd = load writes point_x/point_y at point_index;
//   cmd = run samples the curve at u = 0, u_step, ... while u < 1 (at most
//   MAX_SAMPLES samples); each sample leaves as one output beat
//   with point, first and second derivative, sample_index, and last on the final
//   beat. in_ready is low for the whole run.
//   Multiplier: every multiply but n*(n-1), formed at run start, goes through the
//   single shared multiplier with a registered product. At degree one the second
//   derivative is not computed and is output as zero.
//   Stall: one output register holds a beat; the next sample is computed
//   meanwhile and waits if the receiver has not taken the previous beat.
//   Reset: registers return to point_count 4 and u_step 4096; control points
//   are undefined until loaded.
`include "assert_macros.svh"

module bezier_curve_sampler #(
    parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
    parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [bcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [bcs_pkg::CMD_W-1:0]       cmd,
    input  logic        [bcs_pkg::PIDX_W-1:0]      point_index,
    input  logic signed [bcs_pkg::IN_COORD_W-1:0]  point_x,
    input  logic signed [bcs_pkg::IN_COORD_W-1:0]  point_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_x,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_y,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_dx,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_dy,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_ddx,
    output logic signed [bcs_pkg::OUT_W-1:0]       out_ddy,
    output logic        [bcs_pkg::SIDX_W-1:0]      sample_index,
    output logic                                   last
);
    import bcs_pkg::*;

    localparam int N_W   = $clog2(MAX_POINTS);
    localparam int S_W   = $clog2(MAX_SAMPLES);
    localparam int FAC_W = 2 * N_W;
    localparam int D_W   = COORD_WIDTH + 2;
    localparam int ACC_W = COORD_WIDTH + 22;
    localparam int R_W   = ACC_W - 16;
    localparam int MA_W  = MUL_A_W;
    localparam int MB_W  = (R_W > MUL_A_W) ? R_W : MUL_A_W;
    localparam int P_W   = MA_W + MB_W;

    localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W+1)'(HALF_Q16);

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP, S_PU, S_PV, S_PW, S_ORD, S_W1, S_W2, S_W3, S_W4,
        S_RD, S_DA, S_MX, S_MY, S_MA, S_RX, S_FX, S_FY, S_FZ, S_OUT
    } state_t;

    // Control point store
    logic signed [COORD_WIDTH-1:0] store_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] store_y [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] rd_x_reg, rd_y_reg;
    logic                          wr_en;
    logic [N_W-1:0]                wr_addr, rd_addr;

    // Sequencer and datapath registers
    state_t                    state_reg, state_next;
    logic [PCOUNT_W-1:0]       point_count_reg, point_count_next;
    logic [USTEP_W-1:0]        u_step_reg, u_step_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic [FAC_W-1:0]          fac2_reg, fac2_next;
    logic [USTEP_W-1:0]        u_reg, u_next;
    logic [S_W-1:0]            smp_reg, smp_next;
    logic [N_W-1:0]            kp_reg, kp_next;
    logic [1:0]                o_reg, o_next;
    logic [N_W-1:0]            i_reg, i_next;
    logic [1:0]                j_reg, j_next;
    logic [Q_W-1:0]            pu_reg [MAX_POINTS];
    logic [Q_W-1:0]            pu_next [MAX_POINTS];
    logic [Q_W-1:0]            pv_reg [MAX_POINTS];
    logic [Q_W-1:0]            pv_next [MAX_POINTS];
    logic [Q_W-1:0]            p_reg, p_next;
    logic [Q_W-1:0]            w_reg, w_next;
    logic signed [D_W-1:0]     d_x_reg, d_x_next, d_y_reg, d_y_next;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [R_W-1:0]     r_x_reg, r_x_next, r_y_reg, r_y_next;
    logic signed [OUT_W-1:0]   res_x_reg [3];
    logic signed [OUT_W-1:0]   res_x_next [3];
    logic signed [OUT_W-1:0]   res_y_reg [3];
    logic signed [OUT_W-1:0]   res_y_next [3];
    logic signed [P_W-1:0]     prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic signed [OUT_W-1:0]   out_dx_reg, out_dx_next, out_dy_reg, out_dy_next;
    logic signed [OUT_W-1:0]   out_ddx_reg, out_ddx_next, out_ddy_reg, out_ddy_next;
    logic [SIDX_W-1:0]         sidx_reg, sidx_next;
    logic                      last_reg, last_next;

    // Combinational helpers
    logic                      in_fire;
    logic [N_W-1:0]            m_v;
    logic [N_W-1:0]            n_v;
    logic [Q_W-1:0]            v_v;
    logic [Q_W:0]              u_sum;
    logic                      fin_v;
    logic                      out_free;
    logic [BINOM_W-1:0]        binom_v;
    logic [FAC_W-1:0]          factor_v;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     prod_rnd;
    logic [Q_W-1:0]            q_v;
    logic [Q_W-1:0]            wcap_v;
    logic signed [OUT_W-1:0]   sat_v;
    logic signed [ACC_W:0]     rx_sum, ry_sum;
    logic signed [D_W-1:0]     term_x, term_y;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign m_v      = n_reg - N_W'(o_reg);
    assign v_v      = ONE_Q16 - Q_W'(u_reg);
    assign u_sum    = (Q_W+1)'(u_reg) + (Q_W+1)'(u_step_reg);
    assign fin_v    = u_sum[Q_W-1] || (smp_reg == S_W'(MAX_SAMPLES - 1));
    assign binom_v  = BINOM[BINOM_IDX_W'(m_v)][BINOM_IDX_W'(i_reg)];
    assign prod_rnd = prod_reg + P_W'(HALF_Q16);
    assign q_v      = prod_rnd[Q_W+15:16];
    assign wcap_v   = (prod_reg > P_W'(ONE_Q16)) ? ONE_Q16 : prod_reg[Q_W-1:0];
    assign rx_sum   = {acc_x_reg[ACC_W-1], acc_x_reg} + ACC_HALF;
    assign ry_sum   = {acc_y_reg[ACC_W-1], acc_y_reg} + ACC_HALF;
    assign term_x   = D_W'(rd_x_reg);
    assign term_y   = D_W'(rd_y_reg);

    // Clamp point count to 2..MAX_POINTS and turn it into the degree
    always_comb
    begin
        if (32'(point_count_reg) < 2)
        begin
            n_v = N_W'(1);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_v = N_W'(MAX_POINTS - 1);
        end
        else
        begin
            n_v = N_W'(point_count_reg - PCOUNT_W'(1));
        end
    end

    always_comb
    begin
        case (o_reg)
            2'd0:    factor_v = FAC_W'(1);
            2'd1:    factor_v = FAC_W'(n_reg);
            default: factor_v = fac2_reg;
        endcase
    end

    // Saturate the registered product to signed 32 bits
    always_comb
    begin
        if ((&prod_reg[P_W-1:OUT_W-1]) || !(|prod_reg[P_W-1:OUT_W-1]))
        begin
            sat_v = prod_reg[OUT_W-1:0];
        end
        else if (prod_reg[P_W-1])
        begin
            sat_v = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            sat_v = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PU:
            begin
                mul_a = MA_W'(pu_reg[N_W'(kp_reg - N_W'(1))]);
                mul_b = MB_W'(u_reg);
            end
            S_PV:
            begin
                mul_a = MA_W'(pv_reg[N_W'(kp_reg - N_W'(1))]);
                mul_b = MB_W'(v_v);
            end
            S_W1:
            begin
                mul_a = MA_W'(pu_reg[i_reg]);
                mul_b = MB_W'(pv_reg[N_W'(m_v - i_reg)]);
            end
            S_W3:
            begin
                mul_a = MA_W'(binom_v);
                mul_b = MB_W'(p_reg);
            end
            S_MX:
            begin
                mul_a = MA_W'(w_reg);
                mul_b = MB_W'(d_x_reg);
            end
            S_MY:
            begin
                mul_a = MA_W'(w_reg);
                mul_b = MB_W'(d_y_reg);
            end
            S_FX:
            begin
                mul_a = MA_W'(factor_v);
                mul_b = MB_W'(r_x_reg);
            end
            S_FY:
            begin
                mul_a = MA_W'(factor_v);
                mul_b = MB_W'(r_y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Store access
    assign wr_en   = in_fire && (cmd == CMD_LOAD) && (32'(point_index) < MAX_POINTS);
    assign wr_addr = N_W'(point_index);
    assign rd_addr = i_reg + N_W'(j_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_x[wr_addr] <= COORD_WIDTH'(point_x);
            store_y[wr_addr] <= COORD_WIDTH'(point_y);
        end
        rd_x_reg <= store_x[rd_addr];
        rd_y_reg <= store_y[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        point_count_next = point_count_reg;
        u_step_next      = u_step_reg;
        n_next           = n_reg;
        fac2_next        = fac2_reg;
        u_next           = u_reg;
        smp_next         = smp_reg;
        kp_next          = kp_reg;
        o_next           = o_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        pu_next          = pu_reg;
        pv_next          = pv_reg;
        p_next           = p_reg;
        w_next           = w_reg;
        d_x_next         = d_x_reg;
        d_y_next         = d_y_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        r_x_next         = r_x_reg;
        r_y_next         = r_y_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        out_valid_next   = out_valid_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_dx_next      = out_dx_reg;
        out_dy_next      = out_dy_reg;
        out_ddx_next     = out_ddx_reg;
        out_ddy_next     = out_ddy_reg;
        sidx_next        = sidx_reg;
        last_next        = last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POINT_COUNT: point_count_next = cfg_data[PCOUNT_W-1:0];
                CFG_U_STEP:      u_step_next      = cfg_data[USTEP_W-1:0];
                default:         point_count_next = point_count_reg;
            endcase
        end

        // Drop the beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_RUN))
                begin
                    n_next     = n_v;
                    fac2_next  = FAC_W'(n_v) * FAC_W'(n_v - N_W'(1));
                    u_next     = '0;
                    smp_next   = '0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                pu_next[0] = ONE_Q16;
                pv_next[0] = ONE_Q16;
                kp_next    = N_W'(1);
                state_next = S_PU;
            end
            S_PU:
            begin
                state_next = S_PV;
            end
            S_PV:
            begin
                pu_next[kp_reg] = q_v;
                state_next      = S_PW;
            end
            S_PW:
            begin
                pv_next[kp_reg] = q_v;
                if (kp_reg == n_reg)
                begin
                    o_next     = 2'd0;
                    state_next = S_ORD;
                end
                else
                begin
                    kp_next    = kp_reg + N_W'(1);
                    state_next = S_PU;
                end
            end
            S_ORD:
            begin
                if (N_W'(o_reg) > n_reg)
                begin
                    // Degree one: no second derivative terms
                    res_x_next[o_reg] = '0;
                    res_y_next[o_reg] = '0;
                    state_next        = S_OUT;
                end
                else
                begin
                    acc_x_next = '0;
                    acc_y_next = '0;
                    i_next     = '0;
                    state_next = S_W1;
                end
            end
            S_W1:
            begin
                state_next = S_W2;
            end
            S_W2:
            begin
                p_next     = q_v;
                state_next = S_W3;
            end
            S_W3:
            begin
                state_next = S_W4;
            end
            S_W4:
            begin
                w_next     = wcap_v;
                d_x_next   = '0;
                d_y_next   = '0;
                j_next     = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_DA;
            end
            S_DA:
            begin
                // Difference weights: (1), (-1, 1), (1, -2, 1)
                if ((o_reg == 2'd1) && (j_reg == 2'd0))
                begin
                    d_x_next = d_x_reg - term_x;
                    d_y_next = d_y_reg - term_y;
                end
                else if ((o_reg == 2'd2) && (j_reg == 2'd1))
                begin
                    d_x_next = d_x_reg - (term_x <<< 1);
                    d_y_next = d_y_reg - (term_y <<< 1);
                end
                else
                begin
                    d_x_next = d_x_reg + term_x;
                    d_y_next = d_y_reg + term_y;
                end
                if (j_reg == o_reg)
                begin
                    state_next = S_MX;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_MX:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                acc_x_next = acc_x_reg + ACC_W'(prod_reg);
                state_next = S_MA;
            end
            S_MA:
            begin
                acc_y_next = acc_y_reg + ACC_W'(prod_reg);
                if (i_reg == m_v)
                begin
                    state_next = S_RX;
                end
                else
                begin
                    i_next     = i_reg + N_W'(1);
                    state_next = S_W1;
                end
            end
            S_RX:
            begin
                r_x_next   = rx_sum[ACC_W-1:16];
                r_y_next   = ry_sum[ACC_W-1:16];
                state_next = S_FX;
            end
            S_FX:
            begin
                state_next = S_FY;
            end
            S_FY:
            begin
                res_x_next[o_reg] = sat_v;
                state_next        = S_FZ;
            end
            S_FZ:
            begin
                res_y_next[o_reg] = sat_v;
                if (o_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    o_next     = o_reg + 2'd1;
                    state_next = S_ORD;
                end
            end
            S_OUT:
            begin
                // Hold the sample until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = res_x_reg[0];
                    out_y_next     = res_y_reg[0];
                    out_dx_next    = res_x_reg[1];
                    out_dy_next    = res_y_reg[1];
                    out_ddx_next   = res_x_reg[2];
                    out_ddy_next   = res_y_reg[2];
                    sidx_next      = SIDX_W'(smp_reg);
                    last_next      = fin_v;
                    if (fin_v)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        u_next     = u_sum[USTEP_W-1:0];
                        smp_next   = smp_reg + S_W'(1);
                        state_next = S_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= PCOUNT_RESET;
            u_step_reg      <= USTEP_RESET;
            n_reg           <= '0;
            fac2_reg        <= '0;
            u_reg           <= '0;
            smp_reg         <= '0;
            kp_reg          <= '0;
            o_reg           <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            pu_reg          <= '{default: '0};
            pv_reg          <= '{default: '0};
            p_reg           <= '0;
            w_reg           <= '0;
            d_x_reg         <= '0;
            d_y_reg         <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            r_x_reg         <= '0;
            r_y_reg         <= '0;
            res_x_reg       <= '{default: '0};
            res_y_reg       <= '{default: '0};
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_dx_reg      <= '0;
            out_dy_reg      <= '0;
            out_ddx_reg     <= '0;
            out_ddy_reg     <= '0;
            sidx_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            u_step_reg      <= u_step_next;
            n_reg           <= n_next;
            fac2_reg        <= fac2_next;
            u_reg           <= u_next;
            smp_reg         <= smp_next;
            kp_reg          <= kp_next;
            o_reg           <= o_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            pu_reg          <= pu_next;
            pv_reg          <= pv_next;
            p_reg           <= p_next;
            w_reg           <= w_next;
            d_x_reg         <= d_x_next;
            d_y_reg         <= d_y_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            r_x_reg         <= r_x_next;
            r_y_reg         <= r_y_next;
            res_x_reg       <= res_x_next;
            res_y_reg       <= res_y_next;
            prod_reg        <= prod_next;
            out_valid_reg   <= out_valid_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_dx_reg      <= out_dx_next;
            out_dy_reg      <= out_dy_next;
            out_ddx_reg     <= out_ddx_next;
            out_ddy_reg     <= out_ddy_next;
            sidx_reg        <= sidx_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_dx       = out_dx_reg;
    assign out_dy       = out_dy_reg;
    assign out_ddx      = out_ddx_reg;
    assign out_ddy      = out_ddy_reg;
    assign sample_index = sidx_reg;
    assign last         = last_reg;

    `ASSERT_IMPLIES(a_term_in_degree, state_reg == S_W1, i_reg <= m_v)
    `ASSERT_IMPLIES(a_diff_fetch_bound, state_reg == S_DA, j_reg <= o_reg)
    `ASSERT_NEXT(a_power_product_le_one, state_reg == S_W2, p_reg <= ONE_Q16)
    `ASSERT_NEXT(a_sample_loads_beat, (state_reg == S_OUT) && out_free, out_valid_reg)

endmodule

### bench/bcs_curve_checker.sv
// Checker for the Bezier curve sampler: watches the config, input and output channels,
// predicts every sample beat of a run and compares it field by field.
// Depends on bcs_pkg.
module bcs_curve_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic        [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [bcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic        [bcs_pkg::CMD_W-1:0]       cmd,
    input  logic        [bcs_pkg::PIDX_W-1:0]      point_index,
    input  logic signed [bcs_pkg::IN_COORD_W-1:0]  point_x,
    input  logic signed [bcs_pkg::IN_COORD_W-1:0]  point_y,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_x,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_y,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_dx,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_dy,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_ddx,
    input  logic signed [bcs_pkg::OUT_W-1:0]       out_ddy,
    input  logic        [bcs_pkg::SIDX_W-1:0]      sample_index,
    input  logic                                   last,
    output int                                     errors,
    output int                                     pending
);
    import bcs_pkg::*;

    localparam longint Q_ONE      = 64'sd65536;
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    typedef struct packed {
        logic signed [OUT_W-1:0]  x;
        logic signed [OUT_W-1:0]  y;
        logic signed [OUT_W-1:0]  dx;
        logic signed [OUT_W-1:0]  dy;
        logic signed [OUT_W-1:0]  ddx;
        logic signed [OUT_W-1:0]  ddy;
        logic        [SIDX_W-1:0] index;
        logic                     fin;
    } curve_sample_t;

    logic signed [IN_COORD_W-1:0] pt_x [MAX_POINTS_DEF];
    logic signed [IN_COORD_W-1:0] pt_y [MAX_POINTS_DEF];
    logic        [PCOUNT_W-1:0]   pcount;
    logic        [USTEP_W-1:0]    ustep;
    curve_sample_t                samples_due [$];
    int                           beats;

    function automatic longint unsigned q16_mul(input longint unsigned a, input longint unsigned b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic longint unsigned q16_pow(input longint unsigned base, input int e);
        longint unsigned r;
        r = 64'd65536;
        for (int k = 0; k < e; k++)
            r = q16_mul(r, base);
        return r;
    endfunction

    function automatic longint bern_weight(input int m, input int i, input longint unsigned u);
        longint unsigned c;
        longint unsigned w;
        c = 64'd1;
        for (int k = 0; k < i; k++)
            c = c * longint'(m - k) / longint'(k + 1);
        w = c * q16_mul(q16_pow(u, i), q16_pow(64'd65536 - u, m - i));
        if (w > 64'd65536)
            w = 64'd65536;
        return longint'(w);
    endfunction

    function automatic longint coord(input bit on_y, input int i);
        if (on_y)
            return longint'(pt_y[i]);
        return longint'(pt_x[i]);
    endfunction

    // order 0 is the point, 1 and 2 the derivatives
    function automatic logic signed [OUT_W-1:0] curve_term(input bit on_y, input int n,
                                                           input int order,
                                                           input longint unsigned u);
        longint sum;
        longint d;
        longint scaled;
        int     m;
        if (order > n)
            return '0;
        m = n - order;
        sum = 0;
        for (int i = 0; i <= m; i++)
        begin
            case (order)
                0: d = coord(on_y, i);
                1: d = coord(on_y, i + 1) - coord(on_y, i);
                default: d = coord(on_y, i + 2) - 2 * coord(on_y, i + 1) + coord(on_y, i);
            endcase
            sum += bern_weight(m, i, u) * d;
        end
        // round half up, floor on the arithmetic shift
        scaled = (sum + 64'sd32768) >>> 16;
        if (order >= 1)
            scaled = scaled * n;
        if (order >= 2)
            scaled = scaled * (n - 1);
        if (scaled > SAT_HI)
            scaled = SAT_HI;
        if (scaled < SAT_LO)
            scaled = SAT_LO;
        return scaled[OUT_W-1:0];
    endfunction

    task automatic predict_run();
        int              cnt;
        int              n;
        longint unsigned u;
        longint unsigned nxt;
        bit              fin;
        curve_sample_t   s;
        cnt = int'(pcount);
        if (cnt < 2)
            cnt = 2;
        if (cnt > MAX_POINTS_DEF)
            cnt = MAX_POINTS_DEF;
        n = cnt - 1;
        u = 0;
        fin = 1'b0;
        for (int k = 0; k < MAX_SAMPLES_DEF && !fin && u < Q_ONE; k++)
        begin
            nxt = u + longint'(ustep);
            fin = (nxt >= Q_ONE) || (k + 1 == MAX_SAMPLES_DEF);
            s.x     = curve_term(1'b0, n, 0, u);
            s.y     = curve_term(1'b1, n, 0, u);
            s.dx    = curve_term(1'b0, n, 1, u);
            s.dy    = curve_term(1'b1, n, 1, u);
            s.ddx   = curve_term(1'b0, n, 2, u);
            s.ddy   = curve_term(1'b1, n, 2, u);
            s.index = SIDX_W'(k);
            s.fin   = fin;
            samples_due.insert(samples_due.size(), s);
            u = nxt & 64'h1FFFF;
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s at beat %0d: got %0d, want %0d", name, beats, got, want));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pcount = PCOUNT_RESET;
            ustep  = USTEP_RESET;
            samples_due.delete();
            beats  = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POINT_COUNT: pcount = cfg_data[PCOUNT_W-1:0];
                    CFG_U_STEP:      ustep  = cfg_data[USTEP_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_LOAD)
                begin
                    pt_x[point_index] = point_x;
                    pt_y[point_index] = point_y;
                end
                else
                begin
                    predict_run();
                end
            end
            if (out_valid && out_ready)
            begin
                if (samples_due.size() == 0)
                begin
                    report_mismatch($sformatf("beat with no sample due, sample_index %0d",
                                              sample_index));
                end
                else
                begin
                    curve_sample_t want;
                    want = samples_due.pop_front();
                    check_field("out_x", out_x, want.x);
                    check_field("out_y", out_y, want.y);
                    check_field("out_dx", out_dx, want.dx);
                    check_field("out_dy", out_dy, want.dy);
                    check_field("out_ddx", out_ddx, want.ddx);
                    check_field("out_ddy", out_ddy, want.ddy);
                    check_field("sample_index", sample_index, want.index);
                    check_field("last", last, want.fin);
                end
                beats++;
            end
        end
        pending = samples_due.size();
    end

endmodule

### bench/tb.sv
// Testbench top for the Bezier curve sampler: clock, reset, config writes, point loads
// and runs with random idling; the verdict comes from the checker's counts.
// Depends on bcs_pkg, bezier_curve_sampler and bcs_curve_checker.
module tb;
    import bcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 40_000_000;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          RANDOM_ITEMS  = 351;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_W-1:0]        cmd;
    logic [PIDX_W-1:0]       point_index;
    logic signed [IN_COORD_W-1:0] point_x;
    logic signed [IN_COORD_W-1:0] point_y;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_dx;
    logic signed [OUT_W-1:0] out_dy;
    logic signed [OUT_W-1:0] out_ddx;
    logic signed [OUT_W-1:0] out_ddy;
    logic [SIDX_W-1:0]       sample_index;
    logic                    last;

    int          errors;
    int          pending;
    bit          calm;
    int unsigned cycle_count = 0;

    bezier_curve_sampler dut (.*);

    bcs_curve_checker curve_chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stalls with a chance of 29 in a hundred unless calm
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 29);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bezier_curve_sampler verification failed");
            $finish;
        end
    end

    function automatic logic [IN_COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return IN_COORD_W'($urandom);
        endcase
    endfunction

    // entered just after a falling edge; leaves just after the falling edge past acceptance
    task automatic drive_item(input logic [CMD_W-1:0] c, input logic [PIDX_W-1:0] idx,
                              input logic [IN_COORD_W-1:0] xv, input logic [IN_COORD_W-1:0] yv);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        point_index <= idx;
        point_x     <= xv;
        point_y     <= yv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drive_run();
        drive_item(CMD_RUN, PIDX_W'($urandom), rand_coord(), rand_coord());
    endtask

    // drop valid, wait for every due sample, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] count_word,
                              input logic [CFG_DATA_W-1:0] step_word);
        drain();
        write_reg(CFG_POINT_COUNT, count_word);
        write_reg(CFG_U_STEP, step_word);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          random_items;
        int          phase;
        int          burst;
        int          cnt;
        logic [15:0] step;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_POINT_COUNT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = CMD_LOAD;
        point_index = '0;
        point_x     = '0;
        point_y     = '0;
        calm        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill every point first so no run reads an empty slot
        drive_item(CMD_LOAD, 3'd0, 16'h7FFF, 16'h8000);
        drive_item(CMD_LOAD, 3'd1, 16'h8000, 16'h7FFF);
        drive_item(CMD_LOAD, 3'd2, 16'h0000, 16'h0000);
        drive_item(CMD_LOAD, 3'd3, 16'hFFFF, 16'h0001);
        drive_item(CMD_LOAD, 3'd4, 16'h7FFF, 16'h7FFF);
        drive_item(CMD_LOAD, 3'd5, 16'h8000, 16'h8000);
        drive_item(CMD_LOAD, 3'd6, 16'h0100, 16'hFF00);
        drive_item(CMD_LOAD, 3'd7, 16'h5555, 16'hAAAA);
        drive_run();

        set_config(16'd8, 16'd65535);
        drive_run();
        // degree one: no second derivative
        set_config(16'd2, 16'd1024);
        drive_run();
        // zero step and a count below range: stop at the sample limit
        set_config(16'd0, 16'd0);
        drive_run();
        set_config(16'd15, 16'd1);
        drive_run();
        set_config(16'd3, 16'd32768);
        drive_item(CMD_LOAD, 3'd0, 16'h8000, 16'h7FFF);
        drive_item(CMD_LOAD, 3'd1, 16'h7FFF, 16'h8000);
        drive_item(CMD_LOAD, 3'd2, 16'h8000, 16'h7FFF);
        drive_run();
        set_config(16'd9, 16'd16384);
        drive_run();
        set_config(16'd1, 16'd21846);
        drive_run();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 80)
                cnt = $urandom_range(2, MAX_POINTS_DEF);
            else
                cnt = $urandom_range(0, 15);
            case ($urandom_range(0, 19))
                0:       step = 16'($urandom_range(1024, 2047));
                1, 2, 3: step = 16'($urandom_range(2048, 8191));
                default: step = 16'($urandom_range(8192, 65535));
            endcase
            set_config({12'($urandom), 4'(cnt)}, step);
            // two consecutive bursts with no idling on either side
            calm = (phase == 3 || phase == 4);
            burst = $urandom_range(20, 40);
            if (burst > RANDOM_ITEMS - random_items)
                burst = RANDOM_ITEMS - random_items;
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 28)
                    drive_run();
                else
                    drive_item(CMD_LOAD, PIDX_W'($urandom), rand_coord(), rand_coord());
                random_items++;
            end
            phase++;
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("bezier_curve_sampler verification clean");
        else
            $display("bezier_curve_sampler verification failed");
        $finish;
    end

endmodule
